@@ hdl/learning_remote_relay_switch_unit_macros.svh @@
// Assertion macros used by the checker file of the relay switch.
`ifndef LEARNING_REMOTE_RELAY_SWITCH_UNIT_MACROS_SVH
`define LEARNING_REMOTE_RELAY_SWITCH_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define LRRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lrrs_pkg.sv @@
package lrrs_pkg;

    localparam int MAX_REMOTES      = 16;
    localparam int SLOTS_PER_REMOTE = 4;
    localparam int IDX_W            = (MAX_REMOTES > 1) ? $clog2(MAX_REMOTES) : 1;
    localparam int CNT_W            = $clog2(MAX_REMOTES + 1);

    localparam int ADDR_W    = 16;
    localparam int BTN_W     = 8;
    localparam int CODE_W    = ADDR_W + BTN_W;
    localparam int TICK_W    = 21;
    localparam int PRESS_W   = 6;
    localparam int RELAY_W   = 3;
    localparam int STORED_W  = 5;
    localparam int OUT_TDATA_W = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [BTN_W-1:0]   HOLD_BUTTON = 8'hC3;
    localparam logic [RELAY_W-1:0] ALL_RELAYS  = 3'b111;
    localparam logic [TICK_W-1:0]  TICK_MAX    = {TICK_W{1'b1}};
    localparam logic [PRESS_W-1:0] PRESS_MAX   = {PRESS_W{1'b1}};

    localparam logic [PRESS_W-1:0] RST_LEARN_PRESSES = 6'd20;
    localparam logic [TICK_W-1:0]  RST_LEARN_WINDOW  = 21'd20000;
    localparam logic [TICK_W-1:0]  RST_IDLE_OFF      = 21'd1800000;

    typedef enum logic {
        OP_CODE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_LEARN_PRESSES = 2'd0,
        REG_LEARN_WINDOW  = 2'd1,
        REG_IDLE_OFF      = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [PRESS_W-1:0] learn_presses;
        logic [TICK_W-1:0]  learn_window;
        logic [TICK_W-1:0]  idle_off_ticks;
    } t_cfg;

    typedef struct packed {
        logic [SLOTS_PER_REMOTE-1:0][BTN_W-1:0] slots;
        logic [ADDR_W-1:0]                      addr;
    } t_row;

    typedef struct packed {
        logic [STORED_W-1:0] remotes_stored;
        logic                known_remote;
        logic                learning;
        logic [RELAY_W-1:0]  relays;
    } t_result;

endpackage

@@ hdl/learning_remote_relay_switch_unit.sv @@
// Channel   Dir  Beat contents
// s_t*      in   tdata: remote_code[23:0]; tuser: opcode (0 code, 1 tick)
// m_t*      out  tdata: relays[2:0], learning[3], known_remote[4], remotes_stored[9:5]
// APB       in   learn_presses at 0x0, learn_window at 0x4, idle_off_ticks at 0x8
//
// A tick, a code taken in while learning, or any code while no remote is stored goes
// straight from acceptance to execution without a table search.
// A code for a stored remote ends its search at the matching row, and a code from an
// unknown remote after reading every stored row, as the remote table is searched at
// one read per cycle through the single read port of the memory.
// Reset is synchronous and clears all control state; the table needs no clearing.
// A stalled result stops the next item from finishing but not from being accepted.
module learning_remote_relay_switch_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lrrs_pkg::CODE_W-1:0]         i_s_tdata,  // remote_code[23:0]
    input  logic                                i_s_tuser,  // opcode[0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lrrs_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // relays, learning, known, stored
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [lrrs_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [lrrs_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [lrrs_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                                o_pready
);
    import lrrs_pkg::*;

    t_cfg     r_cfg;
    t_result  result;
    t_reg_idx reg_idx;

    assign reg_idx = t_reg_idx'(i_paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_presses  <= RST_LEARN_PRESSES;
            r_cfg.learn_window   <= RST_LEARN_WINDOW;
            r_cfg.idle_off_ticks <= RST_IDLE_OFF;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (reg_idx)
                REG_LEARN_PRESSES: r_cfg.learn_presses  <= i_pwdata[PRESS_W-1:0];
                REG_LEARN_WINDOW:  r_cfg.learn_window   <= i_pwdata[TICK_W-1:0];
                REG_IDLE_OFF:      r_cfg.idle_off_ticks <= i_pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEARN_PRESSES: o_prdata = APB_DATA_W'(r_cfg.learn_presses);
            REG_LEARN_WINDOW:  o_prdata = APB_DATA_W'(r_cfg.learn_window);
            REG_IDLE_OFF:      o_prdata = APB_DATA_W'(r_cfg.idle_off_ticks);
            default:           o_prdata = '0;
        endcase
    end

    assign o_pready = 1'b1;

    lrrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (result)
    );

    assign o_m_tdata = OUT_TDATA_W'(result);

endmodule

@@ hdl/lrrs_ram.sv @@
module lrrs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_idx,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_idx,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/lrrs_ctrl.sv @@
module lrrs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrrs_pkg::t_cfg                i_cfg,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [lrrs_pkg::CODE_W-1:0]   i_s_tdata,
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output lrrs_pkg::t_result             o_m_tdata
);
    import lrrs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EXEC
    } t_state;

    t_state r_state;

    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [BTN_W-1:0]  r_btn;
    logic [CNT_W-1:0]  r_idx;
    logic              r_chk;
    logic              r_known;
    logic [SLOTS_PER_REMOTE-1:0][BTN_W-1:0] r_slots;
    logic [SLOTS_PER_REMOTE-1:0][BTN_W-1:0] r_bufs;

    logic [RELAY_W-1:0] r_relay;
    logic [PRESS_W-1:0] r_press;
    logic [TICK_W-1:0]  r_ticks;
    logic               r_learn;
    logic [1:0]         r_lslot;
    logic [ADDR_W-1:0]  r_pend;
    logic [CNT_W-1:0]   r_total;

    logic    r_m_valid;
    t_result r_m_data;

    logic [RELAY_W-1:0] n_relay;
    logic [PRESS_W-1:0] n_press;
    logic [TICK_W-1:0]  n_ticks;
    logic               n_learn;
    logic [1:0]         n_lslot;
    logic [ADDR_W-1:0]  n_pend;
    logic [CNT_W-1:0]   n_total;
    logic [SLOTS_PER_REMOTE-1:0][BTN_W-1:0] n_bufs;
    logic               n_wr;
    t_result            n_res;

    logic rd_en;
    logic commit;
    t_row rd_row;
    t_row wr_row;

    assign rd_en  = (r_state == ST_SEARCH) && (r_idx < r_total);
    assign commit = (r_state == ST_EXEC) && (!r_m_valid || i_m_tready);

    assign wr_row.slots = n_bufs;
    assign wr_row.addr  = r_pend;

    lrrs_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (MAX_REMOTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr && commit),
        .i_wr_idx  (r_total[IDX_W-1:0]),
        .i_wr_data (wr_row),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_row)
    );

    always_comb begin
        n_relay = r_relay;
        n_press = r_press;
        n_ticks = r_ticks;
        n_learn = r_learn;
        n_lslot = r_lslot;
        n_pend  = r_pend;
        n_total = r_total;
        n_bufs  = r_bufs;
        n_wr    = 1'b0;
        if (r_op == OP_TICK) begin
            if (n_ticks != TICK_MAX) begin
                n_ticks = n_ticks + 1'b1;
            end
        end else if (r_learn) begin
            n_bufs[r_lslot] = r_btn;
            if (r_lslot == 2'(SLOTS_PER_REMOTE - 1)) begin
                if (r_total < CNT_W'(MAX_REMOTES)) begin
                    n_wr    = 1'b1;
                    n_total = r_total + 1'b1;
                end
                n_learn = 1'b0;
                n_lslot = '0;
                n_press = '0;
                n_ticks = '0;
            end else begin
                n_lslot = r_lslot + 1'b1;
            end
        end else if (r_known) begin
            if (r_btn == HOLD_BUTTON && n_relay != '0) begin
                n_press = PRESS_W'(1);
            end
            for (int s = 0; s < SLOTS_PER_REMOTE; s++) begin
                if (r_slots[s] == r_btn) begin
                    if (s == 0) begin
                        n_relay = (n_relay != '0) ? '0 : ALL_RELAYS;
                    end else begin
                        n_relay = n_relay ^ RELAY_W'(1 << (s - 1));
                    end
                    n_ticks = '0;
                end
            end
        end else begin
            if (n_press == '0) begin
                n_ticks = '0;
            end
            if (n_press != PRESS_MAX) begin
                n_press = n_press + 1'b1;
            end
            if (n_press > i_cfg.learn_presses && n_ticks < i_cfg.learn_window) begin
                if (r_total < CNT_W'(MAX_REMOTES)) begin
                    n_learn = 1'b1;
                    n_lslot = '0;
                    n_pend  = r_addr;
                    n_relay = '0;
                end else begin
                    n_press = '0;
                    n_ticks = '0;
                end
            end else if (n_ticks > i_cfg.learn_window) begin
                n_press = '0;
                n_ticks = '0;
            end
        end
        if (n_relay != '0 && n_ticks > i_cfg.idle_off_ticks && n_press == '0) begin
            n_relay = '0;
        end
        n_res.relays         = n_relay;
        n_res.learning       = n_learn;
        n_res.known_remote   = r_known;
        n_res.remotes_stored = STORED_W'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chk     <= 1'b0;
            r_relay   <= '0;
            r_press   <= '0;
            r_ticks   <= '0;
            r_learn   <= 1'b0;
            r_lslot   <= '0;
            r_pend    <= '0;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_chk <= rd_en;
            if (commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= i_s_tuser;
                        r_addr  <= i_s_tdata[CODE_W-1:BTN_W];
                        r_btn   <= i_s_tdata[BTN_W-1:0];
                        r_idx   <= '0;
                        r_known <= 1'b0;
                        if (i_s_tuser == OP_TICK || r_learn || r_total == '0) begin
                            r_state <= ST_EXEC;
                        end else begin
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (rd_en) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_chk && rd_row.addr == r_addr) begin
                        r_known <= 1'b1;
                        r_slots <= rd_row.slots;
                        r_state <= ST_EXEC;
                    end else if (!rd_en && !r_chk) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (commit) begin
                        r_relay   <= n_relay;
                        r_press   <= n_press;
                        r_ticks   <= n_ticks;
                        r_learn   <= n_learn;
                        r_lslot   <= n_lslot;
                        r_pend    <= n_pend;
                        r_total   <= n_total;
                        r_bufs    <= n_bufs;
                        r_m_data  <= n_res;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

@@ hdl/lrrs_checker.sv @@
`include "learning_remote_relay_switch_unit_macros.svh"

module lrrs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [lrrs_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import lrrs_pkg::*;

    `LRRS_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")
    `LRRS_ASSERT_NEXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready, "input accepted while an item is at work")
    `LRRS_ASSERT_NOW(a_learn_not_known, o_m_tvalid, !(o_m_tdata[3] && o_m_tdata[4]), "known remote reported while learning")
    `LRRS_ASSERT_NOW(a_learn_relays_off, o_m_tvalid && o_m_tdata[3], o_m_tdata[2:0] == 3'b000, "relays on while learning")
    `LRRS_ASSERT_NOW(a_table_bound, o_m_tvalid, o_m_tdata[9:5] <= 5'(MAX_REMOTES), "remote count beyond table size")

endmodule

bind learning_remote_relay_switch_unit lrrs_checker u_lrrs_checker (.*);

@@ sim/tb_learning_remote_relay_switch_unit.sv @@
module tb_learning_remote_relay_switch_unit;

    import lrrs_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = MAX_REMOTES + 8;
    localparam int MAX_PRINTED   = 30;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 80;
    localparam logic [1:0] UNUSED_REG = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [CODE_W-1:0]      i_s_tdata = '0;     // remote_code[23:0]
    logic                   i_s_tuser = 1'b0;   // opcode[0]
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // relays[2:0], learning[3], known[4], stored[9:5]
    logic                   i_psel = 1'b0;
    logic                   i_penable = 1'b0;
    logic                   i_pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  i_paddr = '0;
    logic [APB_DATA_W-1:0]  i_pwdata = '0;
    logic [APB_DATA_W-1:0]  o_prdata;
    logic                   o_pready;

    learning_remote_relay_switch_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    logic [PRESS_W-1:0] cfg_presses = RST_LEARN_PRESSES;
    logic [TICK_W-1:0]  cfg_window  = RST_LEARN_WINDOW;
    logic [TICK_W-1:0]  cfg_idle    = RST_IDLE_OFF;

    logic [ADDR_W-1:0]  tbl_addr   [MAX_REMOTES];
    logic [BTN_W-1:0]   tbl_button [MAX_REMOTES*SLOTS_PER_REMOTE];
    int                 n_stored   = 0;
    int                 cur_remote = 0;
    logic [RELAY_W-1:0] sw_relays  = '0;
    logic [PRESS_W-1:0] press_cnt  = '0;
    logic [TICK_W-1:0]  tick_cnt   = '0;
    logic               learning_on = 1'b0;
    int                 learn_slot = 0;
    logic [ADDR_W-1:0]  learn_addr = '0;

    t_result status_q[$];
    t_result got_status;
    t_result want_status;
    int      fault_count = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;
    int      rx_hold_len = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_learning_remote_relay_switch_unit failed");
            $finish;
        end
    end

    function automatic bit is_stored(input logic [ADDR_W-1:0] a);
        int i;
        is_stored = 1'b0;
        for (i = 0; i < n_stored; i++) begin
            if (tbl_addr[i] == a) begin
                is_stored = 1'b1;
            end
        end
    endfunction

    function automatic logic [ADDR_W-1:0] pick_unknown();
        logic [31:0]       rnd;
        logic [ADDR_W-1:0] a;
        do begin
            rnd = $urandom();
            a = rnd[ADDR_W-1:0];
        end while (is_stored(a));
        return a;
    endfunction

    function automatic t_result switch_step(input t_op op, input logic [CODE_W-1:0] code);
        logic [ADDR_W-1:0] a;
        logic [BTN_W-1:0]  b;
        logic              hit;
        int                i;
        int                s;
        t_result           r;
        a = code[CODE_W-1:BTN_W];
        b = code[BTN_W-1:0];
        hit = 1'b0;
        if (op == OP_TICK) begin
            if (tick_cnt != TICK_MAX) begin
                tick_cnt = tick_cnt + 1'b1;
            end
        end else if (learning_on) begin
            tbl_button[n_stored*SLOTS_PER_REMOTE + learn_slot] = b;
            if (learn_slot == SLOTS_PER_REMOTE - 1) begin
                tbl_addr[n_stored] = learn_addr;
                n_stored++;
                learning_on = 1'b0;
                learn_slot = 0;
                press_cnt = '0;
                tick_cnt = '0;
            end else begin
                learn_slot++;
            end
        end else begin
            for (i = 0; i < n_stored; i++) begin
                if (!hit && tbl_addr[i] == a) begin
                    hit = 1'b1;
                    cur_remote = i;
                end
            end
            if (hit) begin
                if (b == HOLD_BUTTON && sw_relays != '0) begin
                    press_cnt = PRESS_W'(1);
                end
                for (s = 0; s < SLOTS_PER_REMOTE; s++) begin
                    if (tbl_button[cur_remote*SLOTS_PER_REMOTE + s] == b) begin
                        if (s == 0) begin
                            sw_relays = (sw_relays != '0) ? '0 : ALL_RELAYS;
                        end else begin
                            sw_relays[s-1] = ~sw_relays[s-1];
                        end
                        tick_cnt = '0;
                    end
                end
            end else begin
                if (press_cnt == '0) begin
                    tick_cnt = '0;
                end
                if (press_cnt != PRESS_MAX) begin
                    press_cnt = press_cnt + 1'b1;
                end
                if (press_cnt > cfg_presses && tick_cnt < cfg_window) begin
                    if (n_stored < MAX_REMOTES) begin
                        learning_on = 1'b1;
                        learn_slot = 0;
                        learn_addr = a;
                        sw_relays = '0;
                    end else begin
                        press_cnt = '0;
                        tick_cnt = '0;
                    end
                end else if (tick_cnt > cfg_window) begin
                    press_cnt = '0;
                    tick_cnt = '0;
                end
            end
        end
        if (sw_relays != '0 && tick_cnt > cfg_idle && press_cnt == '0) begin
            sw_relays = '0;
        end
        r.relays = sw_relays;
        r.learning = learning_on;
        r.known_remote = hit;
        r.remotes_stored = STORED_W'(n_stored);
        return r;
    endfunction

    task automatic report_fault(input string what, input int got, input int want);
        if (fault_count < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                     cycle_count, what, got, want);
        end
        fault_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_status = o_m_tdata[$bits(t_result)-1:0];
            if (status_q.size() == 0) begin
                report_fault("result beat with nothing outstanding", int'(got_status), 0);
            end else begin
                want_status = status_q.pop_front();
                if (got_status.relays != want_status.relays) begin
                    report_fault("relays", int'(got_status.relays),
                                 int'(want_status.relays));
                end
                if (got_status.learning != want_status.learning) begin
                    report_fault("learning", int'(got_status.learning),
                                 int'(want_status.learning));
                end
                if (got_status.known_remote != want_status.known_remote) begin
                    report_fault("known_remote", int'(got_status.known_remote),
                                 int'(want_status.known_remote));
                end
                if (got_status.remotes_stored != want_status.remotes_stored) begin
                    report_fault("remotes_stored", int'(got_status.remotes_stored),
                                 int'(want_status.remotes_stored));
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_len != 0) begin
                i_m_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_op op, input logic [CODE_W-1:0] code);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= code;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        status_q.push_back(switch_step(op, code));
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (status_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_LEARN_PRESSES) begin
            cfg_presses = value[PRESS_W-1:0];
        end else if (idx == REG_LEARN_WINDOW) begin
            cfg_window = value[TICK_W-1:0];
        end else if (idx == REG_IDLE_OFF) begin
            cfg_idle = value[TICK_W-1:0];
        end
    endtask

    function automatic logic [APB_DATA_W-1:0] pick_span();
        case ($urandom_range(0, 4))
            0: pick_span = 1;
            1: pick_span = $urandom_range(2, 40);
            2: pick_span = $urandom_range(41, 3000);
            3: pick_span = $urandom_range(3001, TICK_MAX - 1);
            default: pick_span = TICK_MAX;
        endcase
    endfunction

    task automatic learn_remote(input logic [ADDR_W-1:0] a);
        int               tries;
        logic [31:0]      rnd;
        logic [BTN_W-1:0] b;
        logic [BTN_W-1:0] prev;
        tries = 0;
        prev = HOLD_BUTTON;
        while (!learning_on && tries < 80) begin
            rnd = $urandom();
            if (rnd[31:28] == 4'd0) begin
                send_item(OP_TICK, rnd[CODE_W-1:0]);
            end else begin
                send_item(OP_CODE, {a, rnd[BTN_W-1:0]});
                if (press_cnt == '0) begin
                    tries = 80;
                end
            end
            tries++;
        end
        while (learning_on) begin
            rnd = $urandom();
            case (rnd[2:0])
                3'd0: b = 8'h00;
                3'd1: b = 8'hFF;
                3'd2: b = HOLD_BUTTON;
                3'd3, 3'd4: b = prev;
                default: b = rnd[15:8];
            endcase
            prev = b;
            send_item(OP_CODE, {rnd[31:16], b});
        end
    endtask

    task automatic random_item();
        int               pick;
        int               r;
        logic [31:0]      rnd;
        logic [BTN_W-1:0] b;
        pick = $urandom_range(0, 99);
        rnd = $urandom();
        if (pick < 40 && n_stored != 0) begin
            r = $urandom_range(0, n_stored - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                    b = tbl_button[r*SLOTS_PER_REMOTE + $urandom_range(0, SLOTS_PER_REMOTE - 1)];
                7: b = HOLD_BUTTON;
                default: b = rnd[BTN_W-1:0];
            endcase
            send_item(OP_CODE, {tbl_addr[r], b});
        end else if (pick < 72) begin
            send_item(OP_TICK, rnd[CODE_W-1:0]);
        end else if (pick < 82) begin
            send_item(OP_CODE, {pick_unknown(), rnd[BTN_W-1:0]});
        end else begin
            send_item(rnd[31] ? OP_TICK : OP_CODE, rnd[CODE_W-1:0]);
        end
    endtask

    task automatic test_directed();
        int          n;
        logic [31:0] rnd;
        write_reg(REG_LEARN_PRESSES, 1);
        write_reg(REG_LEARN_WINDOW, 32'hFFE0_0000 | TICK_MAX);
        write_reg(REG_IDLE_OFF, TICK_MAX);
        write_reg(UNUSED_REG, 32'hFFFF_FFFF);
        send_item(OP_TICK, 24'hFFFFFF);
        send_item(OP_CODE, 24'hFFFFFF);
        send_item(OP_CODE, 24'hFFFF00);
        send_item(OP_CODE, 24'h000000);
        send_item(OP_CODE, 24'hFFFFFF);
        send_item(OP_CODE, {16'h5A5A, HOLD_BUTTON});
        send_item(OP_CODE, 24'h123400);
        wait_all_results();
        write_reg(REG_IDLE_OFF, 1);
        send_item(OP_CODE, 24'hFFFFFF);
        send_item(OP_TICK, 24'h000000);
        send_item(OP_TICK, 24'hFFFFFF);
        send_item(OP_CODE, 24'hFFFF00);
        send_item(OP_CODE, 24'hFFFF5A);
        send_item(OP_CODE, {16'hFFFF, HOLD_BUTTON});
        send_item(OP_TICK, 24'h000000);
        send_item(OP_TICK, 24'h000000);
        send_item(OP_CODE, 24'h1234A5);
        for (n = 0; n < SLOTS_PER_REMOTE; n++) begin
            rnd = $urandom();
            send_item(OP_CODE, rnd[CODE_W-1:0]);
        end
        wait_all_results();
        write_reg(REG_LEARN_WINDOW, 1);
        write_reg(REG_IDLE_OFF, TICK_MAX);
        send_item(OP_CODE, {16'h0001, HOLD_BUTTON});
        send_item(OP_TICK, 24'h000000);
        send_item(OP_TICK, 24'h000000);
        send_item(OP_CODE, 24'h000181);
    endtask

    task automatic test_press_saturation();
        int          n;
        logic [31:0] rnd;
        wait_all_results();
        write_reg(REG_LEARN_PRESSES, 62);
        send_item(OP_CODE, {pick_unknown(), 8'h11});
        send_item(OP_TICK, 24'h000000);
        for (n = 0; n < 66; n++) begin
            rnd = $urandom();
            send_item(OP_CODE, {pick_unknown(), rnd[BTN_W-1:0]});
        end
        send_item(OP_TICK, 24'h000000);
        send_item(OP_CODE, {pick_unknown(), 8'h22});
    endtask

    task automatic test_random_phases();
        int ph;
        int n;
        bit learn_phase;
        for (ph = 0; ph < PHASES; ph++) begin
            wait_all_results();
            learn_phase = $urandom_range(0, 1);
            write_reg(REG_LEARN_PRESSES,
                      learn_phase ? $urandom_range(1, 5) : $urandom_range(1, 62));
            write_reg(REG_LEARN_WINDOW, pick_span());
            write_reg(REG_IDLE_OFF, pick_span());
            if (learn_phase && n_stored < MAX_REMOTES - 2) begin
                learn_remote(pick_unknown());
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
            end
        end
    endtask

    task automatic test_backpressure();
        int n;
        wait_all_results();
        rx_hold_len = 300;
        for (n = 0; n < 40; n++) begin
            random_item();
        end
        wait_all_results();
    endtask

    task automatic test_full_table();
        int n;
        wait_all_results();
        write_reg(REG_LEARN_PRESSES, 1);
        write_reg(REG_LEARN_WINDOW, TICK_MAX);
        write_reg(REG_IDLE_OFF, $urandom_range(1, 30));
        while (n_stored < MAX_REMOTES) begin
            learn_remote(pick_unknown());
        end
        learn_remote(pick_unknown());
        for (n = 0; n < 200; n++) begin
            random_item();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_press_saturation();
        test_random_phases();
        test_backpressure();
        idle_on = 1'b0;
        test_full_table();
        wait_all_results();
        if (fault_count == 0) begin
            $display("tb_learning_remote_relay_switch_unit passed");
        end else begin
            $display("tb_learning_remote_relay_switch_unit failed");
        end
        $finish;
    end

endmodule
